// ===== rtl/core/iwpl_pkg.sv =====
// iwpl_pkg: shared constants, status codes and word types for the improper
// wildcard parameter lookup core. No dependencies; imported by every module.
package iwpl_pkg;

    // table geometry and field widths
    localparam int TABLE_DEPTH = 256;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 16;
    localparam int PARAM_W     = 32;

    // wildcard atom type "X" with zero pad
    localparam logic [KEY_W-1:0] WILD_X = 16'h5800;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status codes
    localparam logic [1:0] ST_MISS   = 2'd0;
    localparam logic [1:0] ST_HIT    = 2'd1;
    localparam logic [1:0] ST_LOADED = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // query broadcast to every cell while one item is in flight
    typedef struct packed {
        logic                      op;
        logic [KEY_W-1:0]          type_a;
        logic [KEY_W-1:0]          type_b;
        logic [KEY_W-1:0]          type_c;
        logic [KEY_W-1:0]          type_d;
        logic signed [PARAM_W-1:0] force_constant;
        logic signed [PARAM_W-1:0] phase_angle;
        logic signed [PARAM_W-1:0] periodicity;
    } t_query;

    // token handed from cell to cell along the chain
    typedef struct packed {
        logic                      valid;
        logic                      done;
        logic                      rev;
        logic                      mid;
        logic [CNT_W-1:0]          remaining;
        logic signed [PARAM_W-1:0] force_constant;
        logic signed [PARAM_W-1:0] phase_angle;
        logic signed [PARAM_W-1:0] periodicity;
    } t_token;

endpackage

// ===== rtl/core/iwpl_cell.sv =====
// iwpl_cell: one table entry (four type keys, three parameters) and one token stage.
// Captures a load or tests a lookup as the token passes. Depends on iwpl_pkg.
module iwpl_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iwpl_pkg::t_query i_query,
    input  iwpl_pkg::t_token i_tok,
    output iwpl_pkg::t_token o_tok
);
    import iwpl_pkg::*;

    // entry storage, undefined until written
    logic [KEY_W-1:0]          r_k0, r_k1, r_k2, r_k3;
    logic signed [PARAM_W-1:0] r_force, r_phase, r_period;

    t_token r_tok;
    t_token n_tok;

    logic w_in_range, w_write, w_hit;
    logic w_m1, w_m2, w_m3, w_m4;
    logic w_e_fwd, w_e_rev, w_e_any;
    logic w_h1, w_h2, w_h3, w_h4;
    logic w_match, w_rev, w_mid;

    // ends test shared by the two centre rules, forward orientation first
    assign w_e_fwd = (r_k0 == i_query.type_a) && (r_k3 == i_query.type_d);
    assign w_e_rev = !w_e_fwd && (r_k3 == i_query.type_a)
                     && ((r_k0 == i_query.type_d) || (r_k0 == WILD_X));
    assign w_e_any = w_e_fwd || w_e_rev
                     || ((r_k0 == WILD_X) && (r_k3 == i_query.type_d));

    // centre and wildcard-centre conditions
    assign w_m1 = (r_k1 == i_query.type_b) && (r_k2 == i_query.type_c);
    assign w_m2 = (r_k1 == i_query.type_c) && (r_k2 == i_query.type_b);
    assign w_m3 = (r_k1 == WILD_X) && (r_k2 == i_query.type_c);
    assign w_m4 = (r_k1 == WILD_X) && (r_k2 == i_query.type_b);

    assign w_h1 = w_m1 && w_e_any;
    assign w_h2 = w_m2 && w_e_any;
    assign w_h3 = w_m3 && ((r_k3 == i_query.type_d) || (r_k3 == i_query.type_a));
    assign w_h4 = w_m4 && ((r_k3 == i_query.type_a) || (r_k3 == i_query.type_d));

    // rule priority picks orientation
    always_comb begin
        w_match = w_h1 || w_h2 || w_h3 || w_h4;
        if (w_h1) begin
            w_rev = w_e_rev;
            w_mid = 1'b1;
        end else if (w_h2) begin
            w_rev = w_e_rev;
            w_mid = 1'b0;
        end else if (w_h3) begin
            w_rev = (r_k3 != i_query.type_d);
            w_mid = 1'b1;
        end else begin
            w_rev = (r_k3 == i_query.type_a);
            w_mid = 1'b0;
        end
    end

    // token decisions at this cell
    assign w_in_range = (i_tok.remaining != '0);
    assign w_write = i_tok.valid && (i_query.op == OP_LOAD) && !i_tok.done && !w_in_range;
    assign w_hit   = i_tok.valid && (i_query.op == OP_LOOKUP) && !i_tok.done
                     && w_in_range && w_match;

    always_comb begin
        n_tok           = i_tok;
        n_tok.remaining = i_tok.remaining - CNT_W'(w_in_range);
        if (w_write) begin
            n_tok.done = 1'b1;
        end
        if (w_hit) begin
            n_tok.done           = 1'b1;
            n_tok.rev            = w_rev;
            n_tok.mid            = w_mid;
            n_tok.force_constant = r_force;
            n_tok.phase_angle    = r_phase;
            n_tok.periodicity    = r_period;
        end
    end

    // token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // entry capture on load
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_k0     <= i_query.type_a;
            r_k1     <= i_query.type_b;
            r_k2     <= i_query.type_c;
            r_k3     <= i_query.type_d;
            r_force  <= i_query.force_constant;
            r_phase  <= i_query.phase_angle;
            r_period <= i_query.periodicity;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/core/improper_wildcard_param_lookup_core.sv =====
// improper_wildcard_param_lookup_core: top level, item control, result buffering
// and the chain of iwpl_cell entries. Depends on iwpl_pkg and iwpl_cell.
//
//  channel | handshake               | word
//  --------+-------------------------+-----------------------------------------
//  in      | i_in_valid / o_in_stall | operation, types a..d, indices, params
//  out     | o_out_valid/ i_out_stall| status, params, ordered indices
//
// one item at a time: a load or lookup walks a token through all TABLE_DEPTH
// cells, one cell per cycle, then its result passes the holding and output registers.
// a load into a full table goes straight to the holding register without entering the chain.
// the next item is taken once the previous result has left the holding register,
// even while the output register still waits on i_out_stall.
// reset (synchronous, active low) empties the table; entries need no clearing.
module improper_wildcard_param_lookup_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [15:0]          i_type_a,
    input  logic [15:0]          i_type_b,
    input  logic [15:0]          i_type_c,
    input  logic [15:0]          i_type_d,
    input  logic [15:0]          i_atom_index_a,
    input  logic [15:0]          i_atom_index_b,
    input  logic [15:0]          i_atom_index_c,
    input  logic [15:0]          i_atom_index_d,
    input  logic signed [31:0]   i_load_force_constant,
    input  logic signed [31:0]   i_load_phase_angle,
    input  logic signed [31:0]   i_load_periodicity,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_force_constant,
    output logic signed [31:0]   o_phase_angle,
    output logic signed [31:0]   o_periodicity,
    output logic [15:0]          o_ordered_first,
    output logic [15:0]          o_ordered_second,
    output logic [15:0]          o_ordered_third,
    output logic [15:0]          o_ordered_fourth
);
    import iwpl_pkg::*;

    // control state
    logic             r_busy;
    logic             r_pend_valid;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    t_token           r_start;
    t_token           n_start;

    // payload state
    t_query                    r_query;
    logic [KEY_W-1:0]          r_idx_a, r_idx_b, r_idx_c, r_idx_d;
    logic [1:0]                r_pend_status;
    logic signed [PARAM_W-1:0] r_pend_force, r_pend_phase, r_pend_period;
    logic [KEY_W-1:0]          r_pend_first, r_pend_second, r_pend_third, r_pend_fourth;
    logic [1:0]                r_out_status;
    logic signed [PARAM_W-1:0] r_out_force, r_out_phase, r_out_period;
    logic [KEY_W-1:0]          r_out_first, r_out_second, r_out_third, r_out_fourth;

    t_token w_tok [0:TABLE_DEPTH];

    logic w_accept, w_full, w_full_load, w_end, w_move;
    logic [1:0]                n_status;
    logic signed [PARAM_W-1:0] n_force, n_phase, n_period;
    logic [KEY_W-1:0]          n_first, n_second, n_third, n_fourth;

    // input handshake
    assign o_in_stall  = r_busy || r_pend_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_full_load = (i_operation == OP_LOAD) && w_full;
    assign w_end       = w_tok[TABLE_DEPTH].valid;
    assign w_move      = r_pend_valid && (!r_out_valid || !i_out_stall);

    // token launched into the chain in the cycle after acceptance
    always_comb begin
        n_start           = '0;
        n_start.valid     = w_accept && !w_full_load;
        n_start.remaining = r_count;
    end

    // chain of cells
    assign w_tok[0] = r_start;
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        iwpl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_query (r_query),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // result word from the token leaving the chain, or a full-table answer
    always_comb begin
        n_status = ST_FULL;
        n_force  = '0;
        n_phase  = '0;
        n_period = '0;
        n_first  = '0;
        n_second = '0;
        n_third  = '0;
        n_fourth = '0;
        if (w_end) begin
            if (r_query.op == OP_LOAD) begin
                n_status = ST_LOADED;
            end else if (w_tok[TABLE_DEPTH].done) begin
                n_status = ST_HIT;
                n_force  = w_tok[TABLE_DEPTH].force_constant;
                n_phase  = w_tok[TABLE_DEPTH].phase_angle;
                n_period = w_tok[TABLE_DEPTH].periodicity;
                n_first  = w_tok[TABLE_DEPTH].rev ? r_idx_d : r_idx_a;
                n_second = w_tok[TABLE_DEPTH].mid ? r_idx_b : r_idx_c;
                n_third  = w_tok[TABLE_DEPTH].mid ? r_idx_c : r_idx_b;
                n_fourth = w_tok[TABLE_DEPTH].rev ? r_idx_a : r_idx_d;
            end else begin
                n_status = ST_MISS;
                n_first  = r_idx_a;
                n_second = r_idx_b;
                n_third  = r_idx_c;
                n_fourth = r_idx_d;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_start      <= '0;
        end else begin
            r_start <= n_start;
            if (w_accept && !w_full_load) begin
                r_busy <= 1'b1;
            end else if (w_end) begin
                r_busy <= 1'b0;
            end
            if (w_accept && (i_operation == OP_LOAD) && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if ((w_accept && w_full_load) || w_end) begin
                r_pend_valid <= 1'b1;
            end else if (w_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query.op             <= i_operation;
            r_query.type_a         <= i_type_a;
            r_query.type_b         <= i_type_b;
            r_query.type_c         <= i_type_c;
            r_query.type_d         <= i_type_d;
            r_query.force_constant <= i_load_force_constant;
            r_query.phase_angle    <= i_load_phase_angle;
            r_query.periodicity    <= i_load_periodicity;
            r_idx_a                <= i_atom_index_a;
            r_idx_b                <= i_atom_index_b;
            r_idx_c                <= i_atom_index_c;
            r_idx_d                <= i_atom_index_d;
        end
    end

    // holding register and output register
    always_ff @(posedge i_clk) begin
        if ((w_accept && w_full_load) || w_end) begin
            r_pend_status <= n_status;
            r_pend_force  <= n_force;
            r_pend_phase  <= n_phase;
            r_pend_period <= n_period;
            r_pend_first  <= n_first;
            r_pend_second <= n_second;
            r_pend_third  <= n_third;
            r_pend_fourth <= n_fourth;
        end
        if (w_move) begin
            r_out_status <= r_pend_status;
            r_out_force  <= r_pend_force;
            r_out_phase  <= r_pend_phase;
            r_out_period <= r_pend_period;
            r_out_first  <= r_pend_first;
            r_out_second <= r_pend_second;
            r_out_third  <= r_pend_third;
            r_out_fourth <= r_pend_fourth;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_force_constant = r_out_force;
    assign o_phase_angle    = r_out_phase;
    assign o_periodicity    = r_out_period;
    assign o_ordered_first  = r_out_first;
    assign o_ordered_second = r_out_second;
    assign o_ordered_third  = r_out_third;
    assign o_ordered_fourth = r_out_fourth;

`ifndef NO_ASSERTIONS
    // a scan in flight and a held result never coexist
    a_busy_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_pend_valid))
        else $error("scan in flight while a result is held");

    // a token leaves the chain only while a scan is in flight
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |-> r_busy)
        else $error("token left the chain with no scan in flight");

    // the fill count never passes the table depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // a full-table load never starts a scan
    a_full_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full_load) |=> (!r_start.valid && r_pend_valid))
        else $error("full-table load entered the chain");
`endif

endmodule

// ===== bench/tb_improper_wildcard_param_lookup_core.sv =====
`timescale 1ns / 100ps
// tb_improper_wildcard_param_lookup_core: self-checking bench for the improper torsion
// lookup core, with a queued driver, a stalling monitor and a built-in predictor.
// Depends on iwpl_pkg and improper_wildcard_param_lookup_core.
module tb_improper_wildcard_param_lookup_core;
    import iwpl_pkg::*;

    localparam int N_RANDOM    = 1630;
    localparam int CYCLE_LIMIT = 2500000;
    localparam int HOLD_CYCLES = 2500;
    localparam int HOLD_AFTER  = 60;

    // one input word as the block sees it
    typedef struct packed {
        logic                      op;
        logic [KEY_W-1:0]          type_a;
        logic [KEY_W-1:0]          type_b;
        logic [KEY_W-1:0]          type_c;
        logic [KEY_W-1:0]          type_d;
        logic [15:0]               index_a;
        logic [15:0]               index_b;
        logic [15:0]               index_c;
        logic [15:0]               index_d;
        logic signed [PARAM_W-1:0] force_k;
        logic signed [PARAM_W-1:0] phase;
        logic signed [PARAM_W-1:0] period;
    } t_torsion_word;

    // one result word
    typedef struct packed {
        logic [1:0]                status;
        logic signed [PARAM_W-1:0] force_k;
        logic signed [PARAM_W-1:0] phase;
        logic signed [PARAM_W-1:0] period;
        logic [15:0]               first;
        logic [15:0]               second;
        logic [15:0]               third;
        logic [15:0]               fourth;
    } t_param_result;

    typedef struct {
        t_torsion_word w;
        int            gap;
    } t_pending_word;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    t_torsion_word drv = '0;
    logic          rx_stall = 1'b0;
    int            rx_wait = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    int            gap_left = 0;
    int            results_seen = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            tx_quiet = 1'b0;
    bit            rx_quiet = 1'b0;
    wire           out_stall = rx_stall || (hold_left != 0);

    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [1:0]                o_status;
    logic signed [31:0]        o_force_constant;
    logic signed [31:0]        o_phase_angle;
    logic signed [31:0]        o_periodicity;
    logic [15:0]               o_ordered_first;
    logic [15:0]               o_ordered_second;
    logic [15:0]               o_ordered_third;
    logic [15:0]               o_ordered_fourth;

    t_pending_word word_queue[$];
    t_param_result expected_params[$];
    logic [63:0]   gen_keys[$];

    // mirror of the entry table
    logic [63:0]        tab_keys   [TABLE_DEPTH];
    logic [PARAM_W-1:0] tab_force  [TABLE_DEPTH];
    logic [PARAM_W-1:0] tab_phase  [TABLE_DEPTH];
    logic [PARAM_W-1:0] tab_period [TABLE_DEPTH];
    int                 tab_count = 0;

    improper_wildcard_param_lookup_core u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (o_in_stall),
        .i_operation           (drv.op),
        .i_type_a              (drv.type_a),
        .i_type_b              (drv.type_b),
        .i_type_c              (drv.type_c),
        .i_type_d              (drv.type_d),
        .i_atom_index_a        (drv.index_a),
        .i_atom_index_b        (drv.index_b),
        .i_atom_index_c        (drv.index_c),
        .i_atom_index_d        (drv.index_d),
        .i_load_force_constant (drv.force_k),
        .i_load_phase_angle    (drv.phase),
        .i_load_periodicity    (drv.period),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (out_stall),
        .o_status              (o_status),
        .o_force_constant      (o_force_constant),
        .o_phase_angle         (o_phase_angle),
        .o_periodicity         (o_periodicity),
        .o_ordered_first       (o_ordered_first),
        .o_ordered_second      (o_ordered_second),
        .o_ordered_third       (o_ordered_third),
        .o_ordered_fourth      (o_ordered_fourth)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // end keys against query ends, exact pair first, then wildcard first key
    function automatic bit ends_match(logic [15:0] k0, logic [15:0] k3, logic [15:0] a,
                                      logic [15:0] d, output bit rev);
        rev = 1'b0;
        if (k0 == a && k3 == d) return 1'b1;
        rev = 1'b1;
        if (k0 == d && k3 == a) return 1'b1;
        if (k0 == WILD_X && k3 == a) return 1'b1;
        rev = 1'b0;
        if (k0 == WILD_X && k3 == d) return 1'b1;
        return 1'b0;
    endfunction

    // one entry against a query; rev swaps the ends, mid keeps centre order b c
    function automatic bit match_improper(logic [63:0] k, logic [15:0] a, logic [15:0] b,
                                          logic [15:0] c, logic [15:0] d,
                                          output bit rev, output bit mid);
        logic [15:0] k0, k1, k2, k3;
        k0 = k[63:48];
        k1 = k[47:32];
        k2 = k[31:16];
        k3 = k[15:0];
        rev = 1'b0;
        mid = 1'b1;
        if (k1 == b && k2 == c && ends_match(k0, k3, a, d, rev)) return 1'b1;
        mid = 1'b0;
        if (k1 == c && k2 == b && ends_match(k0, k3, a, d, rev)) return 1'b1;
        // wildcard second key, first key ignored
        mid = 1'b1;
        if (k1 == WILD_X && k2 == c) begin
            rev = 1'b0;
            if (k3 == d) return 1'b1;
            rev = 1'b1;
            if (k3 == a) return 1'b1;
        end
        mid = 1'b0;
        if (k1 == WILD_X && k2 == b) begin
            rev = 1'b1;
            if (k3 == a) return 1'b1;
            rev = 1'b0;
            if (k3 == d) return 1'b1;
        end
        return 1'b0;
    endfunction

    // expected result of one accepted word, updating the mirror table
    function automatic t_param_result predict_param_result(t_torsion_word w);
        t_param_result r;
        bit            rev, mid;
        int            i;
        r = '0;
        if (w.op == OP_LOAD) begin
            if (tab_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                tab_keys[tab_count]   = {w.type_a, w.type_b, w.type_c, w.type_d};
                tab_force[tab_count]  = w.force_k;
                tab_phase[tab_count]  = w.phase;
                tab_period[tab_count] = w.period;
                tab_count++;
                r.status = ST_LOADED;
            end
            return r;
        end
        // first match in load order wins
        for (i = 0; i < tab_count; i++) begin
            if (match_improper(tab_keys[i], w.type_a, w.type_b, w.type_c, w.type_d,
                               rev, mid)) begin
                r.status  = ST_HIT;
                r.force_k = tab_force[i];
                r.phase   = tab_phase[i];
                r.period  = tab_period[i];
                r.first   = rev ? w.index_d : w.index_a;
                r.second  = mid ? w.index_b : w.index_c;
                r.third   = mid ? w.index_c : w.index_b;
                r.fourth  = rev ? w.index_a : w.index_d;
                return r;
            end
        end
        r.status = ST_MISS;
        r.first  = w.index_a;
        r.second = w.index_b;
        r.third  = w.index_c;
        r.fourth = w.index_d;
        return r;
    endfunction

    // small vocabulary of atom types so that lookups collide with entries
    function automatic logic [15:0] pool_type(int n);
        case (n)
            0:       return "CT";
            1:       return "CA";
            2:       return "CB";
            3:       return "HA";
            4:       return "NA";
            5:       return "OC";
            6:       return {"C", 8'h00};
            default: return {"N", 8'h00};
        endcase
    endfunction

    function automatic logic [15:0] key_pick(int x_pct);
        if ($urandom_range(0, 99) < x_pct) return WILD_X;
        if ($urandom_range(0, 15) == 0) return 16'($urandom);
        return pool_type($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] param_pick();
        if ($urandom_range(0, 7) != 0) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [15:0] index_pick();
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_torsion_word make_word(logic op, logic [15:0] a, logic [15:0] b,
                                                logic [15:0] c, logic [15:0] d);
        t_torsion_word w;
        w.op      = op;
        w.type_a  = a;
        w.type_b  = b;
        w.type_c  = c;
        w.type_d  = d;
        w.index_a = index_pick();
        w.index_b = index_pick();
        w.index_c = index_pick();
        w.index_d = index_pick();
        w.force_k = param_pick();
        w.phase   = param_pick();
        w.period  = param_pick();
        return w;
    endfunction

    function automatic t_torsion_word make_load(logic [15:0] a, logic [15:0] b,
                                                logic [15:0] c, logic [15:0] d,
                                                logic [31:0] f, logic [31:0] p,
                                                logic [31:0] n);
        t_torsion_word w;
        w = make_word(OP_LOAD, a, b, c, d);
        w.force_k = f;
        w.phase   = p;
        w.period  = n;
        return w;
    endfunction

    // queue a word with its sender gap, in quiet or gappy stretches
    task automatic push_word(t_torsion_word w);
        t_pending_word pw;
        if ($urandom_range(0, 15) == 0) tx_quiet = !tx_quiet;
        pw.w   = w;
        pw.gap = tx_quiet ? 0 : $urandom_range(0, 11);
        word_queue.insert(word_queue.size(), pw);
        if (w.op == OP_LOAD && gen_keys.size() < TABLE_DEPTH)
            gen_keys.insert(gen_keys.size(), {w.type_a, w.type_b, w.type_c, w.type_d});
    endtask

    // random word: loads, lookups built from a loaded entry, and noise queries
    task automatic gen_random_word();
        t_torsion_word w;
        logic [15:0]   k[4];
        logic [63:0]   e;
        int            i;
        if ($urandom_range(0, 99) < 20) begin
            w = make_load(key_pick(20), key_pick(20), key_pick(15), key_pick(5),
                          param_pick(), param_pick(), param_pick());
        end else if (gen_keys.size() != 0 && $urandom_range(0, 99) < 75) begin
            e = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
            for (i = 0; i < 4; i++) begin
                k[i] = e[63 - 16 * i -: 16];
                if (k[i] == WILD_X) k[i] = key_pick(5);
            end
            // near miss now and then
            if ($urandom_range(0, 4) == 0) k[$urandom_range(0, 3)] = key_pick(10);
            case ($urandom_range(0, 3))
                0:       w = make_word(OP_LOOKUP, k[0], k[1], k[2], k[3]);
                1:       w = make_word(OP_LOOKUP, k[3], k[1], k[2], k[0]);
                2:       w = make_word(OP_LOOKUP, k[0], k[2], k[1], k[3]);
                default: w = make_word(OP_LOOKUP, k[3], k[2], k[1], k[0]);
            endcase
        end else begin
            w = make_word(OP_LOOKUP, key_pick(10), key_pick(10), key_pick(10), key_pick(10));
        end
        push_word(w);
    endtask

    // driver: present queued words, apply each word's gap after acceptance
    always @(posedge i_clk) begin
        logic next_valid;
        int   next_gap;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            next_valid = in_valid;
            next_gap   = gap_left;
            if (in_valid && !o_in_stall) begin
                expected_params.insert(expected_params.size(), predict_param_result(drv));
                next_valid = 1'b0;
                next_gap   = (word_queue.size() != 0) ? word_queue[0].gap : 0;
            end else if (!in_valid && next_gap != 0) begin
                next_gap = next_gap - 1;
            end
            if (!next_valid && next_gap == 0 && word_queue.size() != 0) begin
                drv <= word_queue[0].w;
                word_queue.delete(0);
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
            gap_left <= next_gap;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // monitor: compare each accepted result word, then draw the next stall
    always @(posedge i_clk) begin
        t_param_result got, want;
        int            w;
        if (!i_rst_n) begin
            rx_stall     <= 1'b0;
            rx_wait      <= 0;
            results_seen <= 0;
        end else if (o_out_valid && !out_stall) begin
            got = '{o_status, o_force_constant, o_phase_angle, o_periodicity,
                    o_ordered_first, o_ordered_second, o_ordered_third, o_ordered_fourth};
            if (expected_params.size() == 0) begin
                $display("%0t: unexpected result word, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_params.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("force_constant", want.force_k, got.force_k);
                check_field("phase_angle", want.phase, got.phase);
                check_field("periodicity", want.period, got.period);
                check_field("ordered_first", 32'(want.first), 32'(got.first));
                check_field("ordered_second", 32'(want.second), 32'(got.second));
                check_field("ordered_third", 32'(want.third), 32'(got.third));
                check_field("ordered_fourth", 32'(want.fourth), 32'(got.fourth));
            end
            results_seen <= results_seen + 1;
            if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
            w = rx_quiet ? 0 : $urandom_range(0, 11);
            rx_wait  <= w;
            rx_stall <= (w != 0);
        end else if (o_out_valid && rx_wait != 0) begin
            rx_wait  <= rx_wait - 1;
            rx_stall <= (rx_wait > 1);
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        t_torsion_word w;
        int            n;

        // empty table miss with extreme indices
        w = make_word(OP_LOOKUP, "CT", "CA", "CB", "HA");
        w.index_a = 16'hFFFF;
        w.index_b = 16'h0000;
        w.index_c = 16'hFFFF;
        w.index_d = 16'h0000;
        push_word(w);

        // exact entry in all four orientations
        push_word(make_load("CT", "CA", "CB", "HA", 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        push_word(make_word(OP_LOOKUP, "CT", "CA", "CB", "HA"));
        push_word(make_word(OP_LOOKUP, "HA", "CA", "CB", "CT"));
        push_word(make_word(OP_LOOKUP, "CT", "CB", "CA", "HA"));
        push_word(make_word(OP_LOOKUP, "HA", "CB", "CA", "CT"));

        // wildcard first key
        push_word(make_load(WILD_X, "NA", "NB", "OC", 32'hFFFF_FFFF, 32'h1, 32'h0001_0000));
        push_word(make_word(OP_LOOKUP, "OC", "NA", "NB", "ZZ"));
        push_word(make_word(OP_LOOKUP, "ZZ", "NA", "NB", "OC"));
        push_word(make_word(OP_LOOKUP, "ZZ", "NB", "NA", "OC"));

        // wildcard second key, both centre orders and both ends
        push_word(make_load("H1", WILD_X, "SS", "TT", 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF));
        push_word(make_word(OP_LOOKUP, "QQ", "RR", "SS", "TT"));
        push_word(make_word(OP_LOOKUP, "TT", "RR", "SS", "QQ"));
        push_word(make_word(OP_LOOKUP, "TT", "SS", "RR", "QQ"));
        push_word(make_word(OP_LOOKUP, "QQ", "SS", "RR", "TT"));

        // wildcard inside the query compares as a plain key
        push_word(make_word(OP_LOOKUP, WILD_X, "NA", "NB", "ZZ"));
        push_word(make_word(OP_LOOKUP, "CT", WILD_X, "CB", "HA"));

        // duplicate entry, first loaded one wins
        push_word(make_load("CT", "CA", "CB", "HA", 32'h1234_5678, 32'h0, 32'h8765_4321));
        push_word(make_word(OP_LOOKUP, "CT", "CA", "CB", "HA"));

        // all-ones and all-zero keys
        push_word(make_load(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 32'h0, 32'h0, 32'h0));
        push_word(make_word(OP_LOOKUP, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
        push_word(make_word(OP_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));

        // random part; enough loads to fill the table and hit table full
        for (n = 0; n < N_RANDOM; n++) gen_random_word();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_queue.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_params.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 16) @(posedge i_clk);

        if (mismatch_count == 0 && expected_params.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/iwpl_pkg.sv
rtl/core/iwpl_cell.sv
rtl/core/improper_wildcard_param_lookup_core.sv
bench/tb_improper_wildcard_param_lookup_core.sv
